/* hw/rtl/psd_pkg.sv */
// Package for the descending pancake sort: item types, control word and microprogram.
`default_nettype none

package psd_pkg;

  localparam int PC_W = 4;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic               item_last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               sorted_last;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN_SEED,
    OP_SCAN,
    OP_FLIP_MAX_INIT,
    OP_FLIP_POS_INIT,
    OP_SWAP_READ,
    OP_SWAP_LO,
    OP_SWAP_HI,
    OP_NEXT_POS,
    OP_OUT_READ,
    OP_OUT_EMIT,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_LAST,
    COND_IDX_GE_CNT,
    COND_IDX_LT_CNT,
    COND_LO_GE_HI,
    COND_POS_NEXT_LT_CNT,
    COND_IDX_NEXT_LT_CNT
  } cond_t;

  typedef struct packed {
    op_t             op;
    wait_t           hold;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  localparam logic [PC_W-1:0] S_LOAD       = 4'd0;
  localparam logic [PC_W-1:0] S_SCAN_INIT  = 4'd1;
  localparam logic [PC_W-1:0] S_SCAN_SEED  = 4'd2;
  localparam logic [PC_W-1:0] S_SCAN       = 4'd3;
  localparam logic [PC_W-1:0] S_FLIP1_INIT = 4'd4;
  localparam logic [PC_W-1:0] S_FLIP1_RD   = 4'd5;
  localparam logic [PC_W-1:0] S_FLIP1_LO   = 4'd6;
  localparam logic [PC_W-1:0] S_FLIP1_HI   = 4'd7;
  localparam logic [PC_W-1:0] S_FLIP2_INIT = 4'd8;
  localparam logic [PC_W-1:0] S_FLIP2_RD   = 4'd9;
  localparam logic [PC_W-1:0] S_FLIP2_LO   = 4'd10;
  localparam logic [PC_W-1:0] S_FLIP2_HI   = 4'd11;
  localparam logic [PC_W-1:0] S_NEXT_POS   = 4'd12;
  localparam logic [PC_W-1:0] S_OUT_READ   = 4'd13;
  localparam logic [PC_W-1:0] S_OUT_EMIT   = 4'd14;
  localparam logic [PC_W-1:0] S_CLEAR      = 4'd15;

  function automatic ctrl_word_t cw(op_t op, wait_t hold, cond_t cond,
                                    logic [PC_W-1:0] target);
    ctrl_word_t w;
    w.op     = op;
    w.hold   = hold;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ctrl_word_t microcode(logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      S_LOAD:       w = cw(OP_LOAD,          WAIT_IN,   COND_NOT_LAST,        S_LOAD);
      S_SCAN_INIT:  w = cw(OP_SCAN_INIT,     WAIT_NONE, COND_NEVER,           S_LOAD);
      S_SCAN_SEED:  w = cw(OP_SCAN_SEED,     WAIT_NONE, COND_IDX_GE_CNT,      S_FLIP1_INIT);
      S_SCAN:       w = cw(OP_SCAN,          WAIT_NONE, COND_IDX_LT_CNT,      S_SCAN);
      S_FLIP1_INIT: w = cw(OP_FLIP_MAX_INIT, WAIT_NONE, COND_NEVER,           S_LOAD);
      S_FLIP1_RD:   w = cw(OP_SWAP_READ,     WAIT_NONE, COND_LO_GE_HI,        S_FLIP2_INIT);
      S_FLIP1_LO:   w = cw(OP_SWAP_LO,       WAIT_NONE, COND_NEVER,           S_LOAD);
      S_FLIP1_HI:   w = cw(OP_SWAP_HI,       WAIT_NONE, COND_ALWAYS,          S_FLIP1_RD);
      S_FLIP2_INIT: w = cw(OP_FLIP_POS_INIT, WAIT_NONE, COND_NEVER,           S_LOAD);
      S_FLIP2_RD:   w = cw(OP_SWAP_READ,     WAIT_NONE, COND_LO_GE_HI,        S_NEXT_POS);
      S_FLIP2_LO:   w = cw(OP_SWAP_LO,       WAIT_NONE, COND_NEVER,           S_LOAD);
      S_FLIP2_HI:   w = cw(OP_SWAP_HI,       WAIT_NONE, COND_ALWAYS,          S_FLIP2_RD);
      S_NEXT_POS:   w = cw(OP_NEXT_POS,      WAIT_NONE, COND_POS_NEXT_LT_CNT, S_SCAN_INIT);
      S_OUT_READ:   w = cw(OP_OUT_READ,      WAIT_NONE, COND_NEVER,           S_LOAD);
      S_OUT_EMIT:   w = cw(OP_OUT_EMIT,      WAIT_OUT,  COND_IDX_NEXT_LT_CNT, S_OUT_READ);
      S_CLEAR:      w = cw(OP_CLEAR,         WAIT_NONE, COND_ALWAYS,          S_LOAD);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pancake_sort_descending_top.sv */
// Top level of the descending pancake sort: microcoded sequencer, datapath and output register.
`default_nettype none

// Items are loaded one per cycle into a store of DEPTH entries until an item
// marked last arrives; items beyond DEPTH are dropped, though a last item still
// ends the set. The block then sorts the n stored values by suffix reversals and
// sends them out largest first, the final one marked. Input is refused from the
// last item until the whole set has been sent. Each position costs a scan of the
// remaining suffix at one element a cycle plus a read, a low write and a high
// write for every swap of the two reversals, as the store has a single write
// port; each output value is read from the store and then emitted, waiting
// while the previous output value has not yet been taken.

module pancake_sort_descending_top #(
  parameter int DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire psd_pkg::in_item_t item,
  output logic                   sorted_valid,
  input  wire logic              sorted_ready,
  output psd_pkg::out_item_t     sorted
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE     = CW'(1);

  logic [psd_pkg::PC_W-1:0] pc;
  psd_pkg::ctrl_word_t      ctrl;

  logic [CW-1:0] cnt;
  logic [CW-1:0] pos;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_d;
  logic [CW-1:0] best;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [31:0]   best_value;

  logic          go;
  logic          jump;
  logic          out_free;
  logic          in_accept;

  logic          re_a;
  logic [AW-1:0] addr_a;
  logic          re_b;
  logic [AW-1:0] addr_b;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [31:0]   rd_a;
  logic [31:0]   rd_b;

  assign ctrl       = psd_pkg::microcode(pc);
  assign out_free   = !sorted_valid || sorted_ready;
  assign item_ready = (ctrl.hold == psd_pkg::WAIT_IN);
  assign in_accept  = item_valid && item_ready;

  always_comb begin
    unique case (ctrl.hold)
      psd_pkg::WAIT_NONE: go = 1'b1;
      psd_pkg::WAIT_IN:   go = item_valid;
      psd_pkg::WAIT_OUT:  go = out_free;
      default:            go = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      psd_pkg::COND_NEVER:           jump = 1'b0;
      psd_pkg::COND_ALWAYS:          jump = 1'b1;
      psd_pkg::COND_NOT_LAST:        jump = !item.item_last;
      psd_pkg::COND_IDX_GE_CNT:      jump = (idx >= cnt);
      psd_pkg::COND_IDX_LT_CNT:      jump = (idx < cnt);
      psd_pkg::COND_LO_GE_HI:        jump = (lo >= hi);
      psd_pkg::COND_POS_NEXT_LT_CNT: jump = ((pos + ONE) < cnt);
      psd_pkg::COND_IDX_NEXT_LT_CNT: jump = ((idx + ONE) < cnt);
      default:                       jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= psd_pkg::S_LOAD;
    end else if (go) begin
      pc <= jump ? ctrl.target : pc + 1'b1;
    end
  end

  always_comb begin
    re_a   = 1'b0;
    addr_a = idx[AW-1:0];
    re_b   = 1'b0;
    addr_b = hi[AW-1:0];
    we     = 1'b0;
    waddr  = cnt[AW-1:0];
    wdata  = item.item_value;
    unique case (ctrl.op)
      psd_pkg::OP_LOAD: begin
        we = in_accept && (cnt < DEPTH_C);
      end
      psd_pkg::OP_SCAN_INIT: begin
        re_a   = 1'b1;
        addr_a = pos[AW-1:0];
      end
      psd_pkg::OP_SCAN_SEED, psd_pkg::OP_SCAN: begin
        re_a = (idx < cnt);
      end
      psd_pkg::OP_SWAP_READ: begin
        re_a   = 1'b1;
        addr_a = lo[AW-1:0];
        re_b   = 1'b1;
      end
      psd_pkg::OP_SWAP_LO: begin
        we    = 1'b1;
        waddr = lo[AW-1:0];
        wdata = rd_b;
      end
      psd_pkg::OP_SWAP_HI: begin
        we    = 1'b1;
        waddr = hi[AW-1:0];
        wdata = rd_a;
      end
      psd_pkg::OP_OUT_READ: begin
        re_a = 1'b1;
      end
      default: begin
      end
    endcase
  end

  psd_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk    (clk),
    .re_a   (re_a),
    .addr_a (addr_a),
    .re_b   (re_b),
    .addr_b (addr_b),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pos <= '0;
    end else if (go) begin
      unique case (ctrl.op)
        psd_pkg::OP_LOAD: begin
          if (cnt < DEPTH_C) begin
            cnt <= cnt + ONE;
          end
          pos <= '0;
        end
        psd_pkg::OP_NEXT_POS: begin
          pos <= pos + ONE;
        end
        psd_pkg::OP_CLEAR: begin
          cnt <= '0;
          pos <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      unique case (ctrl.op)
        psd_pkg::OP_SCAN_INIT: begin
          idx  <= pos + ONE;
          best <= pos;
        end
        psd_pkg::OP_SCAN_SEED: begin
          best_value <= rd_a;
          idx_d      <= idx;
          idx        <= idx + ONE;
        end
        psd_pkg::OP_SCAN: begin
          if ($signed(rd_a) > $signed(best_value)) begin
            best_value <= rd_a;
            best       <= idx_d;
          end
          idx_d <= idx;
          idx   <= idx + ONE;
        end
        psd_pkg::OP_FLIP_MAX_INIT: begin
          lo <= best;
          hi <= cnt - ONE;
        end
        psd_pkg::OP_FLIP_POS_INIT: begin
          lo <= pos;
          hi <= cnt - ONE;
        end
        psd_pkg::OP_SWAP_HI: begin
          lo <= lo + ONE;
          hi <= hi - ONE;
        end
        psd_pkg::OP_NEXT_POS: begin
          idx <= '0;
        end
        psd_pkg::OP_OUT_EMIT: begin
          idx <= idx + ONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_valid <= 1'b0;
    end else if (go && (ctrl.op == psd_pkg::OP_OUT_EMIT)) begin
      sorted_valid <= 1'b1;
    end else if (sorted_ready) begin
      sorted_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (ctrl.op == psd_pkg::OP_OUT_EMIT)) begin
      sorted.sorted_value <= rd_a;
      sorted.sorted_last  <= ((idx + ONE) == cnt);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/psd_store.sv */
// Element store: one write port and two registered read ports.
`default_nettype none

module psd_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          re_a,
  input  wire logic [AW-1:0] addr_a,
  input  wire logic          re_b,
  input  wire logic [AW-1:0] addr_b,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  output logic      [31:0]   rd_a,
  output logic      [31:0]   rd_b
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      rd_a <= mem[addr_a];
    end
    if (re_b) begin
      rd_b <= mem[addr_b];
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench for the descending pancake sort: directed and random sets checked against a local sort.
module tb;

  localparam int DEPTH    = 32;
  localparam int IDLE_PCT = 31;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_ready;
  psd_pkg::in_item_t  item         = '0;
  logic               sorted_valid;
  logic               sorted_ready = 1'b0;
  psd_pkg::out_item_t sorted;

  pancake_sort_descending_top #(.DEPTH(DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .sorted_valid (sorted_valid),
    .sorted_ready (sorted_ready),
    .sorted       (sorted)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bit                 idle_on = 1'b1;
  int                 items_sent;
  int                 sets_sent;
  int                 items_dropped;
  int                 values_checked;
  int                 fail_count;
  logic signed [31:0] set_store [DEPTH];
  int unsigned        set_count;
  psd_pkg::out_item_t sorted_expect [$];

  // Reverses the loaded set from the given position to its end.
  task automatic flip_from(int unsigned from);
    int unsigned        lo;
    int unsigned        hi;
    logic signed [31:0] t;
    lo = from;
    hi = set_count - 1;
    while (lo < hi) begin
      t             = set_store[lo];
      set_store[lo] = set_store[hi];
      set_store[hi] = t;
      lo++;
      hi--;
    end
  endtask

  always @(posedge clk) begin
    if (sorted_ready !== 1'b1 && rst) begin
      sorted_ready <= 1'b0;
    end else if (idle_on) begin
      sorted_ready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      sorted_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : track
    int unsigned        pos;
    int unsigned        best;
    int unsigned        k;
    psd_pkg::out_item_t exp_item;
    if (!rst) begin
      if (item_valid && item_ready) begin
        if (set_count < DEPTH) begin
          set_store[set_count] = item.item_value;
          set_count++;
        end else begin
          items_dropped++;
        end
        if (item.item_last) begin
          for (pos = 0; pos < set_count; pos++) begin
            best = pos;
            for (k = pos + 1; k < set_count; k++) begin
              if (set_store[k] > set_store[best]) begin
                best = k;
              end
            end
            flip_from(best);
            flip_from(pos);
          end
          for (k = 0; k < set_count; k++) begin
            exp_item.sorted_value = set_store[k];
            exp_item.sorted_last  = (k + 1 == set_count);
            sorted_expect.push_back(exp_item);
          end
          set_count = 0;
        end
      end
      if (sorted_valid && sorted_ready) begin
        if (sorted_expect.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected sorted item: value %0d last %0b",
                     sorted.sorted_value, sorted.sorted_last);
          end
        end else begin
          exp_item = sorted_expect.pop_front();
          values_checked++;
          if (sorted.sorted_value !== exp_item.sorted_value ||
              sorted.sorted_last !== exp_item.sorted_last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                       exp_item.sorted_value, exp_item.sorted_last,
                       sorted.sorted_value, sorted.sorted_last);
            end
          end
        end
      end
    end
  end

  task automatic send_item(logic signed [31:0] value, logic last);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= {value, last};
    items_sent++;
    do @(posedge clk); while (!item_ready);
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) begin
      return $urandom;
    end else if (r < 8) begin
      return int'($urandom_range(6)) - 3;
    end else begin
      case ($urandom_range(4))
        0:       return 32'sh7FFFFFFF;
        1:       return 32'sh80000000;
        2:       return 0;
        3:       return -1;
        default: return 1;
      endcase
    end
  endfunction

  task automatic send_set(int size);
    for (int i = 0; i < size; i++) begin
      send_item(pick_value(), i == size - 1);
    end
    sets_sent++;
  endtask

  task automatic test_extremes();
    send_item(32'sh80000000, 1'b1);
    send_item(32'sh7FFFFFFF, 1'b1);
    send_item(32'sh7FFFFFFF, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(32'sh80000001, 1'b0);
    send_item(32'sh7FFFFFFE, 1'b1);
    sets_sent += 3;
  endtask

  task automatic test_ties_and_order();
    for (int i = 0; i < 4; i++) begin
      send_item(5, i == 3);
    end
    send_item(-3, 1'b0);
    send_item(7, 1'b0);
    send_item(-3, 1'b0);
    send_item(7, 1'b0);
    send_item(7, 1'b1);
    for (int i = 1; i <= 6; i++) begin
      send_item(i, i == 6);
    end
    sets_sent += 3;
  endtask

  task automatic test_random_sets(int budget);
    int target;
    target = items_sent + budget;
    while (items_sent < target) begin
      if ($urandom_range(99) < 80) begin
        send_set($urandom_range(1, 8));
      end else begin
        send_set($urandom_range(9, DEPTH));
      end
    end
  endtask

  task automatic test_no_idling(int budget);
    idle_on = 1'b0;
    test_random_sets(budget);
    idle_on = 1'b1;
  endtask

  task automatic test_full_store();
    send_set(DEPTH);
    send_set(DEPTH + 1);
    send_set(DEPTH + 6);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_ties_and_order();
    test_random_sets(140);
    test_no_idling(45);
    test_full_store();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("Sent %0d items in %0d sets, %0d of them dropped at a full store.",
             items_sent, sets_sent, items_dropped);
    $display("Checked %0d sorted values with random idling on both sides.", values_checked);
    if (fail_count == 0) begin
      $display("pancake_sort_descending_top verification clean");
    end else begin
      $display("%0d mismatches in total.", fail_count);
      $display("pancake_sort_descending_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d sorted values still expected.", sorted_expect.size());
    $display("pancake_sort_descending_top verification failed");
    $finish;
  end

endmodule
